// ===== rtl/vvsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vvsl_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MAX_SPEED    = 2'd0,
    REG_MAX_STEP     = 2'd1,
    REG_SINE_SHAPING = 2'd2
  } cfg_reg_e;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 31;

  localparam logic [30:0] MAX_SPEED_RST = 31'd5033165;
  localparam logic [30:0] MAX_STEP_RST  = 31'd40265;

  // 1e-5 and 1e-4 with 40 fraction bits
  localparam logic [63:0] EPS_DIR_Q40 = 64'd10995116;
  localparam logic [63:0] EPS_ACC_Q40 = 64'd109951163;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  // (pi/2)^k / k! in Q2.30 for k = 1,3,5,7,9,11; element 0 is k = 1
  localparam logic [5:0][30:0] SINE_COEF = {
    31'd3864, 31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };

  typedef struct packed {
    logic signed [31:0] current_vel_x;
    logic signed [31:0] current_vel_y;
    logic signed [31:0] current_vel_z;
    logic signed [31:0] desired_vel_x;
    logic signed [31:0] desired_vel_y;
    logic signed [31:0] desired_vel_z;
  } vvsl_in_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
  } vvsl_out_t;

  // sideband carried along the datapath
  typedef struct packed {
    logic [2:0][31:0] du;
    logic [2:0]       dneg;
    logic [2:0][31:0] cur;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] s;
    logic        dir_on;
    logic        cap;
  } lane_t;

  typedef struct packed {
    logic [2:0][31:0] cur;
    logic [2:0]       dneg;
    logic             dir_on;
  } qside_t;

  typedef struct packed {
    logic [2:0][30:0] ev;
    logic [2:0]       eneg;
    logic             halved;
  } eside_t;

  typedef struct packed {
    logic [2:0][30:0] ev;
    logic [2:0]       eneg;
    logic             tiny;
    logic             in_range;
  } mside_t;

endpackage

`default_nettype wire

// ===== rtl/vector_velocity_slew_limiter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Vector velocity slew limiter. Each transfer on the input channel carries a
// present and a requested 3-axis velocity (signed fixed point, FRAC_BITS
// fraction bits); the block returns one acceleration step per transfer, in
// order: the requested speed is capped at max_speed (optionally reshaped by a
// quarter sine below the cap), the change to the present velocity is formed,
// and its length is limited to max_step. One item is accepted every clock
// cycle while in_stall_o is low. The path holds chains of one-bit cells: two
// 32-cell square roots, a 31-cell and two 32-cell dividers, plus the multiply
// and sine stages between them. The pipeline holds while a result is refused
// downstream; a two-deep output buffer lets the input stall flag come straight
// from a register. The user must write configuration only while no item is
// in flight, via cfg_we_i/cfg_idx_i/cfg_data_i; the block does not enforce it.
module vector_velocity_slew_limiter #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [vvsl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [vvsl_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire vvsl_pkg::vvsl_in_t         in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output vvsl_pkg::vvsl_out_t             out_data_o
);

  import vvsl_pkg::*;

  // thresholds at FRAC_BITS, rounded from 40 fraction bits
  localparam logic [63:0] EpsDirW =
    (EPS_DIR_Q40 + (64'd1 << (39 - FRAC_BITS))) >> (40 - FRAC_BITS);
  localparam logic [63:0] EpsAccW =
    (EPS_ACC_Q40 + (64'd1 << (39 - FRAC_BITS))) >> (40 - FRAC_BITS);
  localparam logic [31:0] EpsDir = EpsDirW[31:0];
  localparam logic [31:0] EpsAcc = EpsAccW[31:0];

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [30:0] max_speed_q;
  logic [30:0] max_step_q;
  logic        sine_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= MAX_SPEED_RST;
      max_step_q  <= MAX_STEP_RST;
      sine_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_SPEED:    max_speed_q <= cfg_data_i;
        REG_MAX_STEP:     max_step_q  <= cfg_data_i;
        REG_SINE_SHAPING: sine_q      <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole chain advances together unless the skid slot is
  // occupied; it is filled only while the output register is refused.
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_valid_q;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // ---------------------------------------------------------------------------
  // Stage A: register magnitudes and signs of the requested velocity, and the present velocity
  // ---------------------------------------------------------------------------
  logic [2:0][31:0] dv_in;
  logic [2:0][31:0] cv_in;
  logic             a_valid_q;
  side_t            a_side_q;

  assign dv_in = {in_data_i.desired_vel_z, in_data_i.desired_vel_y, in_data_i.desired_vel_x};
  assign cv_in = {in_data_i.current_vel_z, in_data_i.current_vel_y, in_data_i.current_vel_x};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_side_q.du[i]   <= dv_in[i][31] ? (~dv_in[i] + 32'd1) : dv_in[i];
        a_side_q.dneg[i] <= dv_in[i][31];
        a_side_q.cur[i]  <= cv_in[i];
      end
    end
  end

  // Stage B: squares; stage C: sum of squares
  logic             b_valid_q, c_valid_q;
  side_t            b_side_q, c_side_q;
  logic [2:0][63:0] b_sq_q;
  logic [63:0]      c_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b_sq_q[i] <= 64'(a_side_q.du[i]) * 64'(a_side_q.du[i]);
      end
      b_side_q <= a_side_q;
      c_sum_q  <= b_sq_q[0] + b_sq_q[1] + b_sq_q[2];
      c_side_q <= b_side_q;
    end
  end

  // Requested speed s = floor(sqrt(sum))
  logic        s1_valid;
  logic [31:0] s1_root;
  side_t       s1_side;

  vvsl_sqrt #(.RW(32), .TW($bits(side_t))) u_sqrt_speed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid_q),
    .rad_i   (c_sum_q),
    .tag_i   (c_side_q),
    .valid_o (s1_valid),
    .root_o  (s1_root),
    .tag_o   (s1_side)
  );

  // Stage D: direction and cap decisions
  logic  d_valid_q;
  lane_t d_lane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (en) begin
      d_valid_q <= s1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_lane_q.side   <= s1_side;
      d_lane_q.s      <= s1_root;
      d_lane_q.dir_on <= (s1_root > EpsDir);
      d_lane_q.cap    <= (s1_root > {1'b0, max_speed_q});
    end
  end

  // Sine argument x = (s << 30) / max_speed, Q2.30; used only below the cap
  logic             xd_valid;
  logic [0:0][30:0] xd_quot;
  lane_t            xd_lane;
  logic [0:0][61:0] xd_num;

  assign xd_num[0] = {d_lane_q.s, 30'd0};

  vvsl_div #(.LANES(1), .DW(31), .QW(31), .TW($bits(lane_t))) u_div_arg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid_q),
    .num_i   (xd_num),
    .den_i   (max_speed_q),
    .tag_i   (d_lane_q),
    .valid_o (xd_valid),
    .quot_o  (xd_quot),
    .tag_o   (xd_lane)
  );

  // ---------------------------------------------------------------------------
  // Quarter sine: t = x^2, then Horner over the odd coefficients, one stage
  // per coefficient. Element 0 is seeded with the highest coefficient.
  // ---------------------------------------------------------------------------
  logic        h_valid_q [6];
  logic [30:0] h_x_q     [6];
  logic [30:0] h_t_q     [6];
  logic [30:0] h_p_q     [6];
  lane_t       h_lane_q  [6];
  logic [61:0] x_sq;

  assign x_sq = 62'(xd_quot[0]) * 62'(xd_quot[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q[0] <= 1'b0;
    end else if (en) begin
      h_valid_q[0] <= xd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_x_q[0]    <= xd_quot[0];
      h_t_q[0]    <= x_sq[60:30];
      h_p_q[0]    <= SINE_COEF[5];
      h_lane_q[0] <= xd_lane;
    end
  end

  for (genvar j = 0; j < 5; j++) begin : g_horner
    logic [61:0] tp;
    logic [31:0] p_new;

    assign tp    = 62'(h_t_q[j]) * 62'(h_p_q[j]);
    assign p_new = {1'b0, SINE_COEF[4-j]} - tp[61:30];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        h_valid_q[j+1] <= 1'b0;
      end else if (en) begin
        h_valid_q[j+1] <= h_valid_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        h_x_q[j+1]    <= h_x_q[j];
        h_t_q[j+1]    <= h_t_q[j];
        h_p_q[j+1]    <= p_new[30:0];
        h_lane_q[j+1] <= h_lane_q[j];
      end
    end
  end

  // SP: S = x * p; V1: cap S at one, scale by max_speed; V2: pick the speed
  logic        sp_valid_q, v1_valid_q, v2_valid_q;
  logic [31:0] sp_p_q;
  lane_t       sp_lane_q, v1_lane_q, v2_lane_q;
  logic [61:0] xp;
  logic [30:0] s_capped;
  logic [61:0] v1_prod_q;
  logic [61:0] v_round;
  logic [30:0] v2_v_q;

  assign xp       = 62'(h_x_q[5]) * 62'(h_p_q[5]);
  assign s_capped = (sp_p_q > ONE_Q30) ? ONE_Q30[30:0] : sp_p_q[30:0];
  assign v_round  = v1_prod_q + (62'd1 << 29);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_valid_q <= 1'b0;
      v1_valid_q <= 1'b0;
      v2_valid_q <= 1'b0;
    end else if (en) begin
      sp_valid_q <= h_valid_q[5];
      v1_valid_q <= sp_valid_q;
      v2_valid_q <= v1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_p_q    <= xp[61:30];
      sp_lane_q <= h_lane_q[5];
      v1_prod_q <= 62'(max_speed_q) * 62'(s_capped);
      v1_lane_q <= sp_lane_q;
      v2_lane_q <= v1_lane_q;
      if (v1_lane_q.cap) begin
        v2_v_q <= max_speed_q;
      end else if (sine_q) begin
        v2_v_q <= v_round[60:30];
      end else begin
        v2_v_q <= v1_lane_q.s[30:0];
      end
    end
  end

  // M1: |d| * v; M2: add s/2 for rounding
  logic             m1_valid_q, m2_valid_q;
  lane_t            m1_lane_q, m2_lane_q;
  logic [2:0][63:0] m1_mul_q, m2_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
      m2_valid_q <= 1'b0;
    end else if (en) begin
      m1_valid_q <= v2_valid_q;
      m2_valid_q <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_mul_q[i] <= 64'(v2_lane_q.side.du[i]) * 64'(v2_v_q);
        m2_num_q[i] <= m1_mul_q[i] + 64'(m1_lane_q.s[31:1]);
      end
      m1_lane_q <= v2_lane_q;
      m2_lane_q <= m1_lane_q;
    end
  end

  // Target magnitudes round(|d| * v / s)
  qside_t           q_side_in, q_side;
  logic             q_valid;
  logic [2:0][31:0] q_quot;

  assign q_side_in.cur    = m2_lane_q.side.cur;
  assign q_side_in.dneg   = m2_lane_q.side.dneg;
  assign q_side_in.dir_on = m2_lane_q.dir_on;

  vvsl_div #(.LANES(3), .DW(32), .QW(32), .TW($bits(qside_t))) u_div_target (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m2_valid_q),
    .num_i   (m2_num_q),
    .den_i   (m2_lane_q.s),
    .tag_i   (q_side_in),
    .valid_o (q_valid),
    .quot_o  (q_quot),
    .tag_o   (q_side)
  );

  // ---------------------------------------------------------------------------
  // E1: change e = target - current; E2: magnitude and wide check;
  // E3: halve if wide, square; E4: sum
  // ---------------------------------------------------------------------------
  logic             e1_valid_q, e2_valid_q, e3_valid_q, e4_valid_q;
  logic [2:0][33:0] e1_e_q;
  logic [2:0][32:0] e2_eu_q;
  logic [2:0]       e2_neg_q;
  logic             e2_halved_q;
  logic [2:0][32:0] tgt;
  logic [2:0][33:0] e_abs;
  logic [2:0][30:0] ev;
  logic [2:0]       wide;
  eside_t           e3_side_q, e4_side_q;
  logic [2:0][61:0] e3_sq_q;
  logic [63:0]      e4_sum_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!q_side.dir_on) begin
        tgt[i] = '0;
      end else if (q_side.dneg[i]) begin
        tgt[i] = ~{1'b0, q_quot[i]} + 33'd1;
      end else begin
        tgt[i] = {1'b0, q_quot[i]};
      end
      e_abs[i] = e1_e_q[i][33] ? (~e1_e_q[i] + 34'd1) : e1_e_q[i];
      wide[i]  = e2_eu_q[i][32] | e2_eu_q[i][31];
      ev[i]    = e2_halved_q ? e2_eu_q[i][31:1] : e2_eu_q[i][30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q <= 1'b0;
      e2_valid_q <= 1'b0;
      e3_valid_q <= 1'b0;
      e4_valid_q <= 1'b0;
    end else if (en) begin
      e1_valid_q <= q_valid;
      e2_valid_q <= e1_valid_q;
      e3_valid_q <= e2_valid_q;
      e4_valid_q <= e3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_e_q[i]         <= {tgt[i][32], tgt[i]} - {{2{q_side.cur[i][31]}}, q_side.cur[i]};
        e2_eu_q[i]        <= e_abs[i][32:0];
        e2_neg_q[i]       <= e1_e_q[i][33];
        e3_side_q.ev[i]   <= ev[i];
        e3_side_q.eneg[i] <= e2_neg_q[i];
        e3_sq_q[i]        <= 62'(ev[i]) * 62'(ev[i]);
      end
      e2_halved_q      <= (e_abs[0][32] | e_abs[0][31]) | (e_abs[1][32] | e_abs[1][31])
                        | (e_abs[2][32] | e_abs[2][31]);
      e3_side_q.halved <= |wide;
      e4_sum_q         <= 64'(e3_sq_q[0]) + 64'(e3_sq_q[1]) + 64'(e3_sq_q[2]);
      e4_side_q        <= e3_side_q;
    end
  end

  // Change length n = floor(sqrt(sum))
  logic        n_valid;
  logic [31:0] n_root;
  eside_t      n_side;

  vvsl_sqrt #(.RW(32), .TW($bits(eside_t))) u_sqrt_change (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e4_valid_q),
    .rad_i   (e4_sum_q),
    .tag_i   (e4_side_q),
    .valid_o (n_valid),
    .root_o  (n_root),
    .tag_o   (n_side)
  );

  // F1: tiny / in-range decisions and |e| * max_step; F2: add n/2 for rounding
  logic             f1_valid_q, f2_valid_q;
  logic [31:0]      f1_n_q, f2_n_q;
  mside_t           f1_side_q, f2_side_q;
  logic [2:0][63:0] f1_mul_q, f2_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (en) begin
      f1_valid_q <= n_valid;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f1_mul_q[i] <= 64'(n_side.ev[i]) * 64'(max_step_q);
        f2_num_q[i] <= f1_mul_q[i] + 64'(f1_n_q[31:1]);
      end
      f1_n_q             <= n_root;
      f1_side_q.ev       <= n_side.ev;
      f1_side_q.eneg     <= n_side.eneg;
      f1_side_q.tiny     <= !n_side.halved && (n_root < EpsAcc);
      f1_side_q.in_range <= !n_side.halved && (n_root <= {1'b0, max_step_q});
      f2_n_q             <= f1_n_q;
      f2_side_q          <= f1_side_q;
    end
  end

  // Limited magnitudes round(|e| * max_step / n)
  logic             g_valid;
  logic [2:0][31:0] g_quot;
  mside_t           g_side;

  vvsl_div #(.LANES(3), .DW(32), .QW(32), .TW($bits(mside_t))) u_div_limit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f2_valid_q),
    .num_i   (f2_num_q),
    .den_i   (f2_n_q),
    .tag_i   (f2_side_q),
    .valid_o (g_valid),
    .quot_o  (g_quot),
    .tag_o   (g_side)
  );

  // G: pick zero, the change itself or the limited step; restore the sign
  logic [2:0][31:0] g_mag;
  logic [2:0][31:0] g_res;
  vvsl_out_t        tail_data;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (g_side.tiny) begin
        g_mag[i] = '0;
      end else if (g_side.in_range) begin
        g_mag[i] = {1'b0, g_side.ev[i]};
      end else begin
        g_mag[i] = g_quot[i];
      end
      g_res[i] = g_side.eneg[i] ? (~g_mag[i] + 32'd1) : g_mag[i];
    end
  end

  assign tail_data.accel_x = g_res[0];
  assign tail_data.accel_y = g_res[1];
  assign tail_data.accel_z = g_res[2];

  // ---------------------------------------------------------------------------
  // Output register plus skid slot
  // ---------------------------------------------------------------------------
  logic      out_valid_q;
  vvsl_out_t out_data_q, skid_data_q;
  logic      out_take, tail_push;

  assign out_take  = out_valid_q && !out_stall_i;
  assign tail_push = en && g_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      out_valid_q  <= skid_valid_q || tail_push;
      skid_valid_q <= 1'b0;
    end else if (tail_push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      out_data_q <= skid_valid_q ? skid_data_q : tail_data;
    end else if (tail_push) begin
      skid_data_q <= tail_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // the skid slot is only filled behind a refused output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds a result while the output register is empty");

  // draining the skid slot keeps a result on the output
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid result lost on drain");

  // a tiny change leaves the block as an all-zero step
  a_tiny_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_push && g_side.tiny) |-> (tail_data == '0))
    else $error("tiny change produced a nonzero step");

endmodule

`default_nettype wire

// ===== rtl/vvsl_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One root bit per cell: shift in two radicand bits, try (root<<2)|1.
module vvsl_sqrt_cell #(
  parameter int RW = 32,
  parameter int TW = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [2*RW-1:0]   rad_i,
  input  wire logic [RW:0]       rem_i,
  input  wire logic [RW-1:0]     root_i,
  input  wire logic [TW-1:0]     tag_i,
  output logic                   valid_o,
  output logic [2*RW-1:0]        rad_o,
  output logic [RW:0]            rem_o,
  output logic [RW-1:0]          root_o,
  output logic [TW-1:0]          tag_o
);

  logic [RW+2:0] cand;
  logic [RW+2:0] trial;
  logic [RW+2:0] diff;
  logic          ge;

  assign cand  = {rem_i, rad_i[2*RW-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign diff  = cand - trial;
  assign ge    = (cand >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[2*RW-3:0], 2'b00};
      rem_o  <= ge ? diff[RW:0] : cand[RW:0];
      root_o <= {root_i[RW-2:0], ge};
      tag_o  <= tag_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vvsl_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root: floor(sqrt(rad)), one cell per root bit.
module vvsl_sqrt #(
  parameter int RW = 32,
  parameter int TW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [2*RW-1:0] rad_i,
  input  wire logic [TW-1:0]   tag_i,
  output logic                 valid_o,
  output logic [RW-1:0]        root_o,
  output logic [TW-1:0]        tag_o
);

  logic                 v    [RW+1];
  logic [2*RW-1:0]      rad  [RW+1];
  logic [RW:0]          rem  [RW+1];
  logic [RW-1:0]        root [RW+1];
  logic [TW-1:0]        tag  [RW+1];

  assign v[0]    = valid_i;
  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign tag[0]  = tag_i;

  for (genvar k = 0; k < RW; k++) begin : g_cell
    vvsl_sqrt_cell #(.RW(RW), .TW(TW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (v[k]),
      .rad_i   (rad[k]),
      .rem_i   (rem[k]),
      .root_i  (root[k]),
      .tag_i   (tag[k]),
      .valid_o (v[k+1]),
      .rad_o   (rad[k+1]),
      .rem_o   (rem[k+1]),
      .root_o  (root[k+1]),
      .tag_o   (tag[k+1])
    );
  end

  assign valid_o = v[RW];
  assign root_o  = root[RW];
  assign tag_o   = tag[RW];

endmodule

`default_nettype wire

// ===== rtl/vvsl_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One quotient bit per cell and lane: shift in a numerator bit, subtract if it fits.
module vvsl_div_cell #(
  parameter int LANES = 3,
  parameter int DW    = 32,
  parameter int QW    = 32,
  parameter int TW    = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [DW-1:0]              den_i,
  input  wire logic [LANES-1:0][DW-1:0]   rem_i,
  input  wire logic [LANES-1:0][QW-1:0]   low_i,
  input  wire logic [LANES-1:0][QW-1:0]   quot_i,
  input  wire logic [TW-1:0]              tag_i,
  output logic                            valid_o,
  output logic [DW-1:0]                   den_o,
  output logic [LANES-1:0][DW-1:0]        rem_o,
  output logic [LANES-1:0][QW-1:0]        low_o,
  output logic [LANES-1:0][QW-1:0]        quot_o,
  output logic [TW-1:0]                   tag_o
);

  logic [LANES-1:0][DW:0]   cand;
  logic [LANES-1:0][DW:0]   diff;
  logic [LANES-1:0]         ge;
  logic [LANES-1:0][DW-1:0] rem_d;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cand[l]  = {rem_i[l], low_i[l][QW-1]};
      diff[l]  = cand[l] - {1'b0, den_i};
      ge[l]    = (cand[l] >= {1'b0, den_i});
      rem_d[l] = ge[l] ? diff[l][DW-1:0] : cand[l][DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o <= den_i;
      tag_o <= tag_i;
      for (int l = 0; l < LANES; l++) begin
        rem_o[l]  <= rem_d[l];
        low_o[l]  <= {low_i[l][QW-2:0], 1'b0};
        quot_o[l] <= {quot_i[l][QW-2:0], ge[l]};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vvsl_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, LANES numerators over one divisor.
// Requires num >> QW < den for a meaningful quotient.
module vvsl_div #(
  parameter int LANES = 3,
  parameter int DW    = 32,
  parameter int QW    = 32,
  parameter int TW    = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [LANES-1:0][DW+QW-1:0]   num_i,
  input  wire logic [DW-1:0]                 den_i,
  input  wire logic [TW-1:0]                 tag_i,
  output logic                               valid_o,
  output logic [LANES-1:0][QW-1:0]           quot_o,
  output logic [TW-1:0]                      tag_o
);

  logic                       v    [QW+1];
  logic [DW-1:0]              den  [QW+1];
  logic [LANES-1:0][DW-1:0]   rem  [QW+1];
  logic [LANES-1:0][QW-1:0]   low  [QW+1];
  logic [LANES-1:0][QW-1:0]   quot [QW+1];
  logic [TW-1:0]              tag  [QW+1];

  assign v[0]    = valid_i;
  assign den[0]  = den_i;
  assign quot[0] = '0;
  assign tag[0]  = tag_i;

  for (genvar l = 0; l < LANES; l++) begin : g_head
    assign rem[0][l] = num_i[l][DW+QW-1:QW];
    assign low[0][l] = num_i[l][QW-1:0];
  end

  for (genvar k = 0; k < QW; k++) begin : g_cell
    vvsl_div_cell #(.LANES(LANES), .DW(DW), .QW(QW), .TW(TW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (v[k]),
      .den_i   (den[k]),
      .rem_i   (rem[k]),
      .low_i   (low[k]),
      .quot_i  (quot[k]),
      .tag_i   (tag[k]),
      .valid_o (v[k+1]),
      .den_o   (den[k+1]),
      .rem_o   (rem[k+1]),
      .low_o   (low[k+1]),
      .quot_o  (quot[k+1]),
      .tag_o   (tag[k+1])
    );
  end

  assign valid_o = v[QW];
  assign quot_o  = quot[QW];
  assign tag_o   = tag[QW];

endmodule

`default_nettype wire
